// ===== hw/rtl/scci_pkg.sv =====
// ----------------------------------------------------------------------------
// scci_pkg
// Shared types and codes for the serial calendar clock interface.
// ----------------------------------------------------------------------------
package scci_pkg;

	// bus access kinds
	localparam logic [1:0] FUNC_PORT   = 2'd0;
	localparam logic [1:0] FUNC_STROBE = 2'd1;
	localparam logic [1:0] FUNC_READ   = 2'd2;
	localparam logic [1:0] FUNC_RESET  = 2'd3;

	// command decode (low nibble of the active command)
	localparam logic [3:0] CMD_HOLD      = 4'd0;
	localparam logic [3:0] CMD_READOUT   = 4'd1;
	localparam logic [3:0] CMD_TIME_SET  = 4'd2;
	localparam logic [3:0] CMD_TIME_READ = 4'd3;

	// port command that selects the serial command register
	localparam logic [2:0] PORT_CMD_EXT = 3'd7;

	localparam logic [7:0] ACTIVE_RESET = 8'h80;

	// strobe bit positions
	localparam int STB_CMD   = 1;
	localparam int STB_SHIFT = 2;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] bus_data;
		logic [7:0] now_year;
		logic [3:0] now_month;
		logic [2:0] now_weekday;
		logic [5:0] now_day;
		logic [5:0] now_hour;
		logic [6:0] now_minute;
		logic [6:0] now_second;
	} item_t;

	typedef struct packed {
		logic       read_bit;
		logic       set_pulse;
		logic [7:0] set_year;
		logic [3:0] set_month;
		logic [7:0] set_day;
		logic [7:0] set_hour;
		logic [7:0] set_minute;
		logic [7:0] set_second;
	} result_t;

	typedef logic [5:0][7:0] time_bytes_t;

endpackage

// ===== hw/rtl/scci_in_stage.sv =====
// ----------------------------------------------------------------------------
// scci_in_stage
// Input register: holds one request until the execute stage takes it.
// ----------------------------------------------------------------------------
module scci_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  scci_pkg::item_t in_item,
	input  logic            out_free,
	output logic            fire,
	output scci_pkg::item_t item_s1
);
	import scci_pkg::*;

	logic valid_s1;

	assign fire     = valid_s1 & out_free;
	assign in_ready = ~valid_s1 | fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== hw/rtl/scci_exec.sv =====
// ----------------------------------------------------------------------------
// scci_exec
// Chip state and combinational command / shift execution for one request.
// ----------------------------------------------------------------------------
module scci_exec (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  scci_pkg::item_t   item_s1,
	output scci_pkg::result_t result
);
	import scci_pkg::*;

	time_bytes_t tb_q, tb_d, tb_sh;
	logic [3:0]  sc_q, sc_d, sc_sh;
	logic [7:0]  act_q, act_d;
	logic [2:0]  pc_q, pc_d;
	logic        din_q, din_d;
	logic [7:0]  ls_q, ls_d;
	logic        hold_q, hold_d;
	logic        dout_q, dout_d;
	logic [7:0]  rise;
	logic        ext;
	result_t     res;

	always_comb begin
		tb_d   = tb_q;
		sc_d   = sc_q;
		act_d  = act_q;
		pc_d   = pc_q;
		din_d  = din_q;
		ls_d   = ls_q;
		hold_d = hold_q;
		dout_d = dout_q;
		res    = '0;
		rise   = (ls_q ^ item_s1.bus_data) & item_s1.bus_data;
		ext    = 1'b0;
		tb_sh  = tb_q;
		sc_sh  = sc_q;

		case (item_s1.func)
			FUNC_PORT: begin
				pc_d  = item_s1.bus_data[2:0];
				din_d = item_s1.bus_data[3];
			end
			FUNC_STROBE: begin
				ls_d = item_s1.bus_data;
				if (rise[STB_CMD]) begin
					act_d = (pc_q == PORT_CMD_EXT) ? {ACTIVE_RESET[7:4] , sc_q}
					                               : {5'd0, pc_q};
					case (act_d[3:0])
						CMD_HOLD: begin
							hold_d = 1'b1;
							dout_d = 1'b0;
						end
						CMD_READOUT: begin
							hold_d = 1'b0;
							dout_d = 1'b1;
						end
						CMD_TIME_SET: begin
							res.set_pulse  = 1'b1;
							res.set_year   = act_d[7] ? tb_q[5] : item_s1.now_year;
							res.set_month  = tb_q[4][7:4];
							res.set_day    = tb_q[3];
							res.set_hour   = tb_q[2];
							res.set_minute = tb_q[1];
							res.set_second = tb_q[0];
							hold_d = 1'b1;
							dout_d = 1'b1;
						end
						CMD_TIME_READ: begin
							tb_d[5] = item_s1.now_year;
							tb_d[4] = {item_s1.now_month, 1'b0, item_s1.now_weekday};
							tb_d[3] = {2'b00, item_s1.now_day};
							tb_d[2] = {2'b00, item_s1.now_hour};
							tb_d[1] = {1'b0, item_s1.now_minute};
							tb_d[0] = {1'b0, item_s1.now_second};
							hold_d = 1'b1;
							dout_d = 1'b0;
						end
						default: begin
						end
					endcase
				end
				if (rise[STB_SHIFT]) begin
					ext   = act_d[7];
					tb_sh = tb_d;
					sc_sh = sc_d;
					if (hold_d) begin
						if (ext) begin
							sc_d = {din_q, sc_sh[3:1]};
						end
					end else begin
						for (int i = 0; i < 4; i++) begin
							tb_d[i] = {tb_sh[i+1][0], tb_sh[i][7:1]};
						end
						if (ext) begin
							// 52-bit chain: bytes 0..5 then the serial command
							tb_d[4] = {tb_sh[5][0], tb_sh[4][7:1]};
							tb_d[5] = {sc_sh[0], tb_sh[5][7:1]};
							sc_d    = {din_q, sc_sh[3:1]};
						end else begin
							tb_d[4] = {din_q, tb_sh[4][7:1]};
						end
					end
				end
			end
			FUNC_RESET: begin
				tb_d   = '0;
				sc_d   = '0;
				act_d  = ACTIVE_RESET;
				pc_d   = '0;
				din_d  = 1'b0;
				ls_d   = '0;
				hold_d = 1'b0;
				dout_d = 1'b0;
			end
			default: begin
			end
		endcase

		res.read_bit = dout_d & tb_d[0][0];
	end

	assign result = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tb_q   <= '0;
			sc_q   <= '0;
			act_q  <= ACTIVE_RESET;
			pc_q   <= '0;
			din_q  <= 1'b0;
			ls_q   <= '0;
			hold_q <= 1'b0;
			dout_q <= 1'b0;
		end else if (fire) begin
			tb_q   <= tb_d;
			sc_q   <= sc_d;
			act_q  <= act_d;
			pc_q   <= pc_d;
			din_q  <= din_d;
			ls_q   <= ls_d;
			hold_q <= hold_d;
			dout_q <= dout_d;
		end
	end

`ifndef SYNTHESIS
	a_reset_state: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.func == FUNC_RESET |=>
			act_q == ACTIVE_RESET && !hold_q && !dout_q && tb_q == '0)
		else $error("reset request did not restore state");

	a_read_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.func == FUNC_READ |=>
			$stable(tb_q) && $stable(act_q) && $stable(sc_q) && $stable(ls_q))
		else $error("data read changed state");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(tb_q) && $stable(sc_q) && $stable(hold_q))
		else $error("state moved without a request");

	a_set_only_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.set_pulse |-> item_s1.func == FUNC_STROBE && rise[STB_CMD])
		else $error("time set without command strobe");
`endif

endmodule

// ===== hw/rtl/scci_out_stage.sv =====
// ----------------------------------------------------------------------------
// scci_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module scci_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  scci_pkg::result_t result,
	output logic              out_free,
	output logic              out_valid,
	input  logic              out_ready,
	output scci_pkg::result_t result_q
);
	import scci_pkg::*;

	logic valid_q;

	assign out_free  = ~valid_q | out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
		end
	end

endmodule

// ===== hw/rtl/serial_calendar_clock_interface_core.sv =====
// ----------------------------------------------------------------------------
// serial_calendar_clock_interface_core
// Bus-access model of a serial calendar clock chip's command/shift interface.
// ----------------------------------------------------------------------------
// Each request is one bus access (port write, strobe write, data read or
// reset) and yields exactly one result: the serial data-out bit and, when a
// time set command ran, the time fields to be written. A request passes an
// input register and a combinational execute stage into a result register,
// so one request is taken per clock and its result is held in the result
// register until taken; only a stalled result register slows intake.
// Chip state updates in request order at the execute stage.
module serial_calendar_clock_interface_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] bus_data,
	input  logic [7:0] now_year,
	input  logic [3:0] now_month,
	input  logic [2:0] now_weekday,
	input  logic [5:0] now_day,
	input  logic [5:0] now_hour,
	input  logic [6:0] now_minute,
	input  logic [6:0] now_second,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       read_bit,
	output logic       set_pulse,
	output logic [7:0] set_year,
	output logic [3:0] set_month,
	output logic [7:0] set_day,
	output logic [7:0] set_hour,
	output logic [7:0] set_minute,
	output logic [7:0] set_second
);
	import scci_pkg::*;

	item_t   in_item, item_s1;
	result_t result, result_q;
	logic    fire, out_free;

	assign in_item = '{func: func, bus_data: bus_data, now_year: now_year,
		now_month: now_month, now_weekday: now_weekday, now_day: now_day,
		now_hour: now_hour, now_minute: now_minute, now_second: now_second};

	scci_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_free (out_free),
		.fire     (fire),
		.item_s1  (item_s1)
	);

	scci_exec u_exec (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.result  (result)
	);

	scci_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.result    (result),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_q  (result_q)
	);

	assign read_bit   = result_q.read_bit;
	assign set_pulse  = result_q.set_pulse;
	assign set_year   = result_q.set_year;
	assign set_month  = result_q.set_month;
	assign set_day    = result_q.set_day;
	assign set_hour   = result_q.set_hour;
	assign set_minute = result_q.set_minute;
	assign set_second = result_q.set_second;

endmodule

// ===== verif/calendar_clock_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_clock_checker
// Watches both channels of the calendar clock interface, keeps its own copy
// of the chip state, predicts the answer to every accepted request and
// compares each accepted result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module calendar_clock_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] bus_data,
	input  logic [7:0] now_year,
	input  logic [3:0] now_month,
	input  logic [2:0] now_weekday,
	input  logic [5:0] now_day,
	input  logic [5:0] now_hour,
	input  logic [6:0] now_minute,
	input  logic [6:0] now_second,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       read_bit,
	input  logic       set_pulse,
	input  logic [7:0] set_year,
	input  logic [3:0] set_month,
	input  logic [7:0] set_day,
	input  logic [7:0] set_hour,
	input  logic [7:0] set_minute,
	input  logic [7:0] set_second,
	output int         fail_count,
	output int         answers_pending
);
	import scci_pkg::*;

	// shadow of the chip state
	time_bytes_t tbytes;
	logic [3:0]  ser_cmd;
	logic [7:0]  act_cmd;
	logic [2:0]  port_cmd;
	logic        din;
	logic [7:0]  last_stb;
	logic        hold;
	logic        dout;

	result_t answer_q[$];
	int      err_total;
	item_t   req;
	result_t want;
	result_t ans;

	task automatic reset_chip();
		tbytes   = '0;
		ser_cmd  = '0;
		act_cmd  = ACTIVE_RESET;
		port_cmd = '0;
		din      = 1'b0;
		last_stb = '0;
		hold     = 1'b0;
		dout     = 1'b0;
	endtask

	task automatic run_command(input item_t r, inout result_t a);
		logic ext;
		if (port_cmd == PORT_CMD_EXT)
			act_cmd = ACTIVE_RESET | {4'b0, ser_cmd};
		else
			act_cmd = {5'b0, port_cmd};
		ext = act_cmd[7];
		case (act_cmd[3:0])
			CMD_HOLD: begin
				hold = 1'b1;
				dout = 1'b0;
			end
			CMD_READOUT: begin
				hold = 1'b0;
				dout = 1'b1;
			end
			CMD_TIME_SET: begin
				a.set_pulse  = 1'b1;
				a.set_year   = ext ? tbytes[5] : r.now_year;
				a.set_month  = tbytes[4][7:4];
				a.set_day    = tbytes[3];
				a.set_hour   = tbytes[2];
				a.set_minute = tbytes[1];
				a.set_second = tbytes[0];
				hold = 1'b1;
				dout = 1'b1;
			end
			CMD_TIME_READ: begin
				tbytes[5] = r.now_year;
				tbytes[4] = {r.now_month, 1'b0, r.now_weekday};
				tbytes[3] = {2'b00, r.now_day};
				tbytes[2] = {2'b00, r.now_hour};
				tbytes[1] = {1'b0, r.now_minute};
				tbytes[0] = {1'b0, r.now_second};
				hold = 1'b1;
				dout = 1'b0;
			end
			default: begin
			end
		endcase
	endtask

	task automatic shift_chain();
		logic ext;
		int   i;
		ext = act_cmd[7];
		if (hold) begin
			// only the serial command register moves, and only when extended
			if (ext)
				ser_cmd = {din, ser_cmd[3:1]};
		end else begin
			for (i = 0; i < 4; i++)
				tbytes[i] = {tbytes[i+1][0], tbytes[i][7:1]};
			if (ext) begin
				tbytes[4] = {tbytes[5][0], tbytes[4][7:1]};
				tbytes[5] = {ser_cmd[0], tbytes[5][7:1]};
				ser_cmd   = {din, ser_cmd[3:1]};
			end else begin
				tbytes[4] = {din, tbytes[4][7:1]};
			end
		end
	endtask

	task automatic chip_access(input item_t r, output result_t a);
		logic [7:0] rise;
		a = '0;
		case (r.func)
			FUNC_PORT: begin
				port_cmd = r.bus_data[2:0];
				din      = r.bus_data[3];
			end
			FUNC_STROBE: begin
				rise     = ~last_stb & r.bus_data;
				last_stb = r.bus_data;
				// command runs before the shift when both rise together
				if (rise[STB_CMD])
					run_command(r, a);
				if (rise[STB_SHIFT])
					shift_chain();
			end
			FUNC_RESET: begin
				reset_chip();
			end
			default: begin
			end
		endcase
		a.read_bit = dout & tbytes[0][0];
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			err_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_chip();
			answer_q.delete();
			err_total = 0;
			fail_count      <= 0;
			answers_pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (answer_q.size() == 0) begin
					$error("result seen with no request outstanding");
					err_total++;
				end else begin
					want = answer_q.pop_front();
					check_field("read_bit", 8'(want.read_bit), 8'(read_bit));
					check_field("set_pulse", 8'(want.set_pulse), 8'(set_pulse));
					check_field("set_year", want.set_year, set_year);
					check_field("set_month", 8'(want.set_month), 8'(set_month));
					check_field("set_day", want.set_day, set_day);
					check_field("set_hour", want.set_hour, set_hour);
					check_field("set_minute", want.set_minute, set_minute);
					check_field("set_second", want.set_second, set_second);
				end
			end
			if (in_valid && in_ready) begin
				req = {func, bus_data, now_year, now_month, now_weekday,
					now_day, now_hour, now_minute, now_second};
				chip_access(req, ans);
				answer_q.push_back(ans);
			end
			fail_count      <= err_total;
			answers_pending <= answer_q.size();
		end
	end

endmodule

// ===== verif/serial_calendar_clock_interface_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_calendar_clock_interface_core_tb
// Drives bus access requests into the calendar clock interface: a directed
// walk of every command, edge and plain shift case, then random protocol
// sequences (command strobes, shift bursts, extended command loads) mixed
// with noise. Both sides stall at random; a checker predicts and compares.
// ----------------------------------------------------------------------------
module serial_calendar_clock_interface_core_tb;
	import scci_pkg::*;

	localparam int         RANDOM_ITEMS   = 1750;
	localparam int         QUIET_FROM     = 700;
	localparam int         QUIET_TO       = 1000;
	localparam int         WATCHDOG_LIMIT = 1000;
	localparam int         DRAIN_CYCLES   = 8;
	localparam logic [7:0] STB_CMD_BIT    = 8'(1 << STB_CMD);
	localparam logic [7:0] STB_SHIFT_BIT  = 8'(1 << STB_SHIFT);
	localparam logic [7:0] STB_BOTH       = STB_CMD_BIT | STB_SHIFT_BIT;
	// port command with no decode of its own
	localparam logic [2:0] PORT_CMD_SPARE = 3'd5;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] func;
	logic [7:0] bus_data;
	logic [7:0] now_year;
	logic [3:0] now_month;
	logic [2:0] now_weekday;
	logic [5:0] now_day;
	logic [5:0] now_hour;
	logic [6:0] now_minute;
	logic [6:0] now_second;
	logic       out_valid;
	logic       out_ready;
	logic       read_bit;
	logic       set_pulse;
	logic [7:0] set_year;
	logic [3:0] set_month;
	logic [7:0] set_day;
	logic [7:0] set_hour;
	logic [7:0] set_minute;
	logic [7:0] set_second;

	int   fail_count;
	int   answers_pending;
	int   sent = 0;
	int   stall_cycles = 0;
	logic idle_on;
	logic vary_now = 1'b0;

	serial_calendar_clock_interface_core dut (.*);

	calendar_clock_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ready <= !idle_on || ($urandom_range(0, 99) >= 17);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// one request, held until taken
	task automatic access(input logic [1:0] f, input logic [7:0] d);
		while (idle_on && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		if (vary_now) begin
			now_year    <= 8'($urandom);
			now_month   <= 4'($urandom);
			now_weekday <= 3'($urandom);
			now_day     <= 6'($urandom);
			now_hour    <= 6'($urandom);
			now_minute  <= 7'($urandom);
			now_second  <= 7'($urandom);
		end
		func     <= f;
		bus_data <= d;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
		idle_on <= !(sent >= QUIET_FROM && sent < QUIET_TO);
	endtask

	task automatic port_write(input logic [2:0] cmd, input logic d_in);
		access(FUNC_PORT, {4'($urandom), d_in, cmd});
	endtask

	// raise the given strobe bits, then drop both again
	task automatic strobe_pulse(input logic [7:0] mask);
		access(FUNC_STROBE, (8'($urandom) & ~STB_BOTH) | mask);
		access(FUNC_STROBE, 8'($urandom) & ~STB_BOTH);
	endtask

	initial begin
		int         start;
		int         n;
		int         k;
		int         kind;
		logic [3:0] target;

		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		idle_on     <= 1'b1;
		func        <= FUNC_READ;
		bus_data    <= 8'h00;
		now_year    <= 8'hFF;
		now_month   <= 4'hF;
		now_weekday <= 3'h7;
		now_day     <= 6'h3F;
		now_hour    <= 6'h3F;
		now_minute  <= 7'h7F;
		now_second  <= 7'h7F;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk
		access(FUNC_READ, 8'hFF);
		port_write(3'(CMD_TIME_READ), 1'b0);
		strobe_pulse(STB_CMD_BIT);            // latch all-ones time
		vary_now = 1'b1;
		port_write(3'(CMD_READOUT), 1'b1);
		strobe_pulse(STB_CMD_BIT);
		strobe_pulse(STB_SHIFT_BIT);          // 40-bit chain
		access(FUNC_READ, 8'h00);
		port_write(3'(CMD_TIME_SET), 1'b0);
		strobe_pulse(STB_BOTH);               // set, then shift in hold
		port_write(3'(CMD_HOLD), 1'b1);
		strobe_pulse(STB_CMD_BIT);
		strobe_pulse(STB_SHIFT_BIT);          // hold, plain command: nothing moves
		access(FUNC_STROBE, 8'hFF);
		access(FUNC_STROBE, 8'hFF);           // level held, no edge
		port_write(PORT_CMD_EXT, 1'b1);
		strobe_pulse(STB_CMD_BIT);            // extended, serial command 0
		strobe_pulse(STB_SHIFT_BIT);          // serial register only
		port_write(PORT_CMD_SPARE, 1'b0);
		strobe_pulse(STB_CMD_BIT);            // modes left alone
		access(FUNC_RESET, 8'hA5);

		start = sent;
		while (sent - start < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				port_write(3'($urandom), 1'($urandom));
				strobe_pulse(($urandom_range(0, 4) == 0) ? STB_BOTH : STB_CMD_BIT);
				if ($urandom_range(0, 9) < 3)
					access(FUNC_READ, 8'($urandom));
			end else if (kind < 55) begin
				n = $urandom_range(1, 16);
				for (k = 0; k < n; k++) begin
					port_write(3'($urandom), 1'($urandom));
					strobe_pulse(STB_SHIFT_BIT);
					if ($urandom_range(0, 1) == 1)
						access(FUNC_READ, 8'($urandom));
				end
			end else if (kind < 80) begin
				// load the serial command register, LSB first, then run it
				case ($urandom_range(0, 4))
					0: target = CMD_HOLD;
					1: target = CMD_READOUT;
					2: target = CMD_TIME_SET;
					3: target = CMD_TIME_READ;
					default: target = 4'($urandom);
				endcase
				port_write(PORT_CMD_EXT, 1'($urandom));
				strobe_pulse(STB_CMD_BIT);
				for (k = 0; k < 4; k++) begin
					port_write(PORT_CMD_EXT, target[k]);
					strobe_pulse(STB_SHIFT_BIT);
				end
				port_write(PORT_CMD_EXT, 1'($urandom));
				strobe_pulse(STB_CMD_BIT);
				if ($urandom_range(0, 1) == 1)
					access(FUNC_READ, 8'($urandom));
			end else if (kind < 99) begin
				access(2'($urandom_range(0, 2)), 8'($urandom));
			end else begin
				access(FUNC_RESET, 8'($urandom));
			end
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (answers_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && answers_pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/scci_pkg.sv
hw/rtl/scci_in_stage.sv
hw/rtl/scci_exec.sv
hw/rtl/scci_out_stage.sv
hw/rtl/serial_calendar_clock_interface_core.sv
verif/calendar_clock_checker.sv
verif/serial_calendar_clock_interface_core_tb.sv
